// ===== hw/rtl/sse_pkg.sv =====
// Package for the selection sort engine: sizes, value types, sequencer step codes,
// the control store (microcode ROM) and the structs passed between modules.
// No dependencies.
package sse_pkg;

    localparam int CAPACITY   = 32;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic [CNT_W-1:0]             cnt_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD_I,
        ST_LD_I,
        ST_SCAN,
        ST_EMIT
    } step_t;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_START_END,
        COND_J_MORE,
        COND_LAST
    } cond_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_I,
        RD_J
    } rd_sel_t;

    typedef struct packed {
        logic    busy;
        logic    store_in;
        rd_sel_t rd_sel;
        logic    init_j;
        logic    load_cur;
        logic    compare;
        logic    emit;
        cond_t   cond;
        step_t   tgt_true;
        step_t   tgt_false;
    } ucode_t;

    typedef struct packed {
        logic start_end;
        logic j_more;
        logic last;
    } flags_t;

    typedef struct packed {
        logic   we;
        idx_t   waddr;
        value_t wdata;
        idx_t   raddr;
    } mem_req_t;

    // Control store. Each step: datapath controls, branch condition, two targets.
    function automatic ucode_t ucode_rom(input step_t s);
        ucode_t w;
        w = '{busy: 1'b0, store_in: 1'b0, rd_sel: RD_NONE, init_j: 1'b0,
              load_cur: 1'b0, compare: 1'b0, emit: 1'b0, cond: COND_ALWAYS,
              tgt_true: ST_LOAD, tgt_false: ST_LOAD};
        unique case (s)
            ST_LOAD:
            begin
                w.store_in  = 1'b1;
                w.cond      = COND_START_END;
                w.tgt_true  = ST_RD_I;
                w.tgt_false = ST_LOAD;
            end
            ST_RD_I:
            begin
                w.busy      = 1'b1;
                w.rd_sel    = RD_I;
                w.init_j    = 1'b1;
                w.tgt_true  = ST_LD_I;
                w.tgt_false = ST_LD_I;
            end
            ST_LD_I:
            begin
                w.busy      = 1'b1;
                w.rd_sel    = RD_J;
                w.load_cur  = 1'b1;
                w.cond      = COND_J_MORE;
                w.tgt_true  = ST_SCAN;
                w.tgt_false = ST_EMIT;
            end
            ST_SCAN:
            begin
                w.busy      = 1'b1;
                w.rd_sel    = RD_J;
                w.compare   = 1'b1;
                w.cond      = COND_J_MORE;
                w.tgt_true  = ST_SCAN;
                w.tgt_false = ST_EMIT;
            end
            ST_EMIT:
            begin
                w.busy      = 1'b1;
                w.emit      = 1'b1;
                w.cond      = COND_LAST;
                w.tgt_true  = ST_LOAD;
                w.tgt_false = ST_RD_I;
            end
            default:
            begin
                w.cond      = COND_ALWAYS;
                w.tgt_true  = ST_LOAD;
                w.tgt_false = ST_LOAD;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/sse_mem.sv =====
// Value store of the selection sort engine: one write port, one registered read port.
// Depends on sse_pkg.
module sse_mem (
    input  logic              clk,
    input  sse_pkg::mem_req_t req,
    output sse_pkg::value_t   rd_data
);
    import sse_pkg::*;

    value_t mem [CAPACITY];
    value_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data_reg <= mem[req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/sse_seq.sv =====
// Microcode sequencer: step counter, control store lookup and conditional branch.
// Depends on sse_pkg.
module sse_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  sse_pkg::flags_t flags,
    output sse_pkg::ucode_t word
);
    import sse_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    ucode_t word_cur;
    logic   take;

    always_comb
    begin
        word_cur = ucode_rom(step_reg);
    end

    always_comb
    begin
        unique case (word_cur.cond)
            COND_ALWAYS:    take = 1'b1;
            COND_START_END: take = flags.start_end;
            COND_J_MORE:    take = flags.j_more;
            COND_LAST:      take = flags.last;
            default:        take = 1'b1;
        endcase
        step_next = take ? word_cur.tgt_true : word_cur.tgt_false;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_LOAD;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign word = word_cur;

endmodule

// ===== hw/rtl/selection_sort_engine_top.sv =====
// Selection sort engine. Loading: one value per cycle, busy low while loading.
// After the end-marked transfer a set of n values is sorted and emitted: each
// position takes a read step, a load step, a scan step for each remaining entry
// on the single store read port, and an emit step. Each result is registered.
// Reset returns to loading with an empty set; store contents are undefined
// until written. Results cannot be stalled.
module selection_sort_engine_top (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  sse_pkg::value_t         value,
    input  logic                    end_of_set,
    output logic                    strobe,
    output sse_pkg::value_t         sorted_value,
    output logic                    last_of_run,
    output logic                    overflowed
);
    import sse_pkg::*;

    ucode_t   word;
    flags_t   flags;
    mem_req_t req;
    value_t   rd_data;

    cnt_t   count_reg, count_next;
    logic   ovf_reg, ovf_next;
    cnt_t   i_reg, i_next;
    cnt_t   j_reg, j_next;
    value_t min_reg, min_next;
    value_t cur_reg, cur_next;
    idx_t   pick_reg, pick_next;
    idx_t   addr_q_reg;

    logic   strobe_reg, strobe_next;
    value_t sorted_value_reg, sorted_value_next;
    logic   last_reg, last_next;
    logic   ovf_out_reg, ovf_out_next;

    logic   in_xfer;
    logic   has_room;

    sse_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .word  (word)
    );

    sse_mem u_mem (
        .clk     (clk),
        .req     (req),
        .rd_data (rd_data)
    );

    assign busy     = word.busy;
    assign in_xfer  = start && !word.busy;
    assign has_room = count_reg < cnt_t'(CAPACITY);

    always_comb
    begin
        flags.start_end = in_xfer && end_of_set;
        flags.j_more    = j_reg < count_reg;
        flags.last      = cnt_t'(i_reg + cnt_t'(1)) == count_reg;
    end

    always_comb
    begin
        req.we    = (word.store_in && in_xfer && has_room) || word.emit;
        req.waddr = word.emit ? pick_reg : count_reg[IDX_W-1:0];
        req.wdata = word.emit ? cur_reg : value;
        unique case (word.rd_sel)
            RD_I:    req.raddr = i_reg[IDX_W-1:0];
            RD_J:    req.raddr = j_reg[IDX_W-1:0];
            default: req.raddr = '0;
        endcase
    end

    always_comb
    begin
        count_next        = count_reg;
        ovf_next          = ovf_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        min_next          = min_reg;
        cur_next          = cur_reg;
        pick_next         = pick_reg;
        strobe_next       = 1'b0;
        sorted_value_next = sorted_value_reg;
        last_next         = last_reg;
        ovf_out_next      = ovf_out_reg;

        if (word.store_in && in_xfer)
        begin
            if (has_room)
            begin
                count_next = cnt_t'(count_reg + cnt_t'(1));
            end
            else
            begin
                ovf_next = 1'b1;
            end
            if (end_of_set)
            begin
                i_next = '0;
            end
        end

        if (word.init_j)
        begin
            j_next = cnt_t'(i_reg + cnt_t'(1));
        end
        else if (word.rd_sel == RD_J)
        begin
            j_next = cnt_t'(j_reg + cnt_t'(1));
        end

        if (word.load_cur)
        begin
            min_next  = rd_data;
            cur_next  = rd_data;
            pick_next = i_reg[IDX_W-1:0];
        end

        // strict less-than keeps the first minimum found
        if (word.compare && (rd_data < min_reg))
        begin
            min_next  = rd_data;
            pick_next = addr_q_reg;
        end

        // emit the minimum; the displaced entry moves to where the minimum was
        if (word.emit)
        begin
            strobe_next       = 1'b1;
            sorted_value_next = min_reg;
            last_next         = flags.last;
            ovf_out_next      = ovf_reg;
            if (flags.last)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                i_next = cnt_t'(i_reg + cnt_t'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            i_reg      <= '0;
            j_reg      <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg          <= min_next;
        cur_reg          <= cur_next;
        pick_reg         <= pick_next;
        addr_q_reg       <= req.raddr;
        sorted_value_reg <= sorted_value_next;
        last_reg         <= last_next;
        ovf_out_reg      <= ovf_out_next;
    end

    assign strobe       = strobe_reg;
    assign sorted_value = sorted_value_reg;
    assign last_of_run  = last_reg;
    assign overflowed   = ovf_out_reg;

endmodule

// ===== hw/rtl/sse_checker.sv =====
// Port-level checker for the selection sort engine, bound to the top level.
// Depends on sse_pkg.
module sse_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input sse_pkg::value_t value,
    input logic            end_of_set,
    input logic            strobe,
    input sse_pkg::value_t sorted_value,
    input logic            last_of_run,
    input logic            overflowed
);
    import sse_pkg::*;

    // an end-marked transfer starts the sort pass
    a_end_starts_sort: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && end_of_set |=> busy)
        else $error("end transfer did not start sort");

    // results before the final one come while sorting
    a_mid_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_of_run |-> busy)
        else $error("intermediate result while idle");

    // the final result shows up as the engine returns to loading
    a_last_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last_of_run |-> !busy)
        else $error("final result while still busy");

    // results never come in consecutive cycles
    a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("back-to-back results");

    // no results while loading a set
    a_no_result_loading: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !$past(busy) |-> !strobe)
        else $error("result while loading");

endmodule

bind selection_sort_engine_top sse_checker u_sse_checker (.*);

// ===== dv/sort_result_checker.sv =====
// Checker for the selection sort engine: watches value transfers and result strobes,
// keeps its own copy of the value set, predicts the sorted output and compares.
// Depends on sse_pkg (value_t, CAPACITY).
module sort_result_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            busy,
    input  sse_pkg::value_t value,
    input  logic            end_of_set,
    input  logic            strobe,
    input  sse_pkg::value_t sorted_value,
    input  logic            last_of_run,
    input  logic            overflowed,
    output int              mismatches,
    output int              outstanding
);
    import sse_pkg::*;

    typedef struct packed {
        value_t val;
        logic   last;
        logic   ovf;
    } sorted_entry_t;

    value_t        set_vals [CAPACITY];
    int            set_len;
    logic          set_dropped;
    sorted_entry_t sorted_due [$];
    int            err_count;

    task automatic report_mismatch(input string msg);
        $display("checker: mismatch: %s", msg);
        err_count++;
    endtask

    // Store one value; on the end mark, sort the set and queue the whole run.
    task automatic absorb_value(input value_t v, input logic eos);
        int     i;
        int     j;
        int     pick;
        value_t tmp;
        sorted_entry_t ent;
        if (set_len < CAPACITY)
        begin
            set_vals[set_len] = v;
            set_len++;
        end
        else
            set_dropped = 1'b1;
        if (eos)
        begin
            for (i = 0; i + 1 < set_len; i++)
            begin
                pick = i;
                for (j = i + 1; j < set_len; j++)
                    if (set_vals[j] < set_vals[pick])
                        pick = j;
                tmp            = set_vals[i];
                set_vals[i]    = set_vals[pick];
                set_vals[pick] = tmp;
            end
            for (i = 0; i < set_len; i++)
            begin
                ent.val  = set_vals[i];
                ent.last = (i == set_len - 1);
                ent.ovf  = set_dropped;
                sorted_due.insert(sorted_due.size(), ent);
            end
            set_len     = 0;
            set_dropped = 1'b0;
        end
    endtask

    task automatic check_result();
        sorted_entry_t want;
        if (sorted_due.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result %0d", sorted_value));
            return;
        end
        want = sorted_due.pop_front();
        if (sorted_value !== want.val)
            report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                      sorted_value, want.val));
        if (last_of_run !== want.last)
            report_mismatch($sformatf("last_of_run %b, expected %b (value %0d)",
                                      last_of_run, want.last, want.val));
        if (overflowed !== want.ovf)
            report_mismatch($sformatf("overflowed %b, expected %b (value %0d)",
                                      overflowed, want.ovf, want.val));
    endtask

    initial
    begin
        err_count = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_len     = 0;
            set_dropped = 1'b0;
            sorted_due.delete();
            outstanding <= 0;
            mismatches  <= err_count;
        end
        else
        begin
            // a final result can share an edge with the next transfer; results pop
            // the front and new runs append, so order here is free
            if (strobe === 1'b1)
                check_result();
            if (start === 1'b1 && busy === 1'b0)
                absorb_value(value, end_of_set);
            outstanding <= sorted_due.size();
            mismatches  <= err_count;
        end
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for selection_sort_engine_top: clock, reset, value-set stimulus
// and the final verdict. Prediction and comparison live in sort_result_checker.
// Depends on sse_pkg, selection_sort_engine_top and sort_result_checker.
module tb;
    import sse_pkg::*;

    localparam int RUN_LIMIT   = 400000;
    localparam int ITEM_TARGET = 420;
    localparam value_t VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam value_t VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    typedef enum int {
        SPREAD_WIDE,
        SPREAD_NARROW,
        SPREAD_BOUNDS
    } spread_t;

    logic   clk        = 1'b0;
    logic   rst_n      = 1'b0;
    logic   start      = 1'b0;
    value_t value      = '0;
    logic   end_of_set = 1'b0;
    logic   busy;
    logic   strobe;
    value_t sorted_value;
    logic   last_of_run;
    logic   overflowed;
    int     mismatches;
    int     outstanding;
    int     cycle_count = 0;
    int     items_sent  = 0;
    bit     idle_on     = 1'b1;

    always #6 clk = ~clk;

    selection_sort_engine_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .end_of_set   (end_of_set),
        .strobe       (strobe),
        .sorted_value (sorted_value),
        .last_of_run  (last_of_run),
        .overflowed   (overflowed)
    );

    sort_result_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .end_of_set   (end_of_set),
        .strobe       (strobe),
        .sorted_value (sorted_value),
        .last_of_run  (last_of_run),
        .overflowed   (overflowed),
        .mismatches   (mismatches),
        .outstanding  (outstanding)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: done, errors");
            $finish;
        end
    end

    // One value transfer; returns right after the edge that took it.
    task automatic send_value(input value_t v, input logic eos);
        if (idle_on && $urandom_range(99) < 30)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        start      <= 1'b1;
        value      <= v;
        end_of_set <= eos;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        items_sent++;
    endtask

    // Hold off until every queued result has come out.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    function automatic value_t rand_value(input spread_t spread);
        int near_zero;
        case (spread)
            SPREAD_NARROW:
            begin
                near_zero = int'($urandom_range(8)) - 4;
                return value_t'(near_zero);
            end
            SPREAD_BOUNDS:
                case ($urandom_range(4))
                    0:       return VAL_MIN;
                    1:       return VAL_MAX;
                    2:       return '0;
                    3:       return '1;
                    default: return value_t'(1);
                endcase
            default:
                return value_t'($urandom);
        endcase
    endfunction

    task automatic send_set(input value_t vals[$]);
        int k;
        for (k = 0; k < vals.size(); k++)
            send_value(vals[k], k == vals.size() - 1);
    endtask

    initial
    begin
        value_t  vals[$];
        int      set_idx;
        int      set_size;
        int      k;
        int      pick;
        spread_t spread;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: lone values at both ends of the range, mixed extremes, duplicates
        vals = '{VAL_MAX};
        send_set(vals);
        vals = '{value_t'(0), '1, VAL_MIN, VAL_MAX, value_t'(1)};
        send_set(vals);
        vals = '{value_t'(5), value_t'(5), value_t'(-5), value_t'(5)};
        send_set(vals);
        vals = '{VAL_MIN};
        send_set(vals);
        drain_results();

        set_idx = 0;
        while (items_sent < ITEM_TARGET)
        begin
            pick = $urandom_range(99);
            if (set_idx == 2)
                set_size = CAPACITY + 2;
            else if (set_idx == 5)
                set_size = CAPACITY;
            else if (pick < 60)
                set_size = $urandom_range(1, 6);
            else if (pick < 80)
                set_size = $urandom_range(7, 16);
            else if (pick < 88)
                set_size = $urandom_range(17, CAPACITY - 1);
            else if (pick < 93)
                set_size = CAPACITY;
            else
                set_size = $urandom_range(CAPACITY + 1, CAPACITY + 4);

            // a stretch of sets sent back to back with no gaps
            idle_on = !(set_idx >= 6 && set_idx < 14);

            pick = $urandom_range(99);
            spread = (pick < 50) ? SPREAD_WIDE : (pick < 80) ? SPREAD_NARROW : SPREAD_BOUNDS;
            vals.delete();
            for (k = 0; k < set_size; k++)
                vals.insert(vals.size(), ($urandom_range(9) == 0) ? rand_value(SPREAD_BOUNDS)
                                                                   : rand_value(spread));
            send_set(vals);

            if (set_idx % 9 == 4)
                drain_results();
            set_idx++;
        end

        drain_results();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
